// ===== design/pfc_pkg.sv =====
// Shared types, constants and letter-code helpers for the Playfair digram cipher.
package pfc_pkg;

  localparam int unsigned SIDE    = 5;
  localparam int unsigned CODE_W  = 5;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CODES   = 25;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z = 8'h5A;
  // Codes at or above this index skip the letter J.
  localparam logic [CODE_W-1:0] CODE_J = 5'd9;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_KEY01 = 2'd0;
  localparam logic [1:0] REG_KEY23 = 2'd1;
  localparam logic [1:0] REG_KEY4  = 2'd2;
  localparam logic [1:0] REG_DIR   = 2'd3;

  // Key square indexed [row][col]
  typedef logic [SIDE-1:0][SIDE-1:0][CODE_W-1:0] key_sq_t;

  // What one lane found for its letter
  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } pos_t;

  // One result word
  typedef struct packed {
    logic              bad;
    logic [CHAR_W-1:0] first;
    logic [CHAR_W-1:0] second;
  } res_t;

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_A) && (c <= CHAR_Z);
  endfunction

  // ASCII letter to square code; J folds onto I
  function automatic logic [CODE_W-1:0] letter_code(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = c - CHAR_A;
    if (v >= {3'b000, CODE_J}) begin
      v = v - 8'd1;
    end
    return v[CODE_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] code_letter(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] r;
    if (code >= CODE_W'(CODES)) begin
      r = CHAR_Z;
    end else if (code < CODE_J) begin
      r = CHAR_A + {3'b000, code};
    end else begin
      r = CHAR_A + {3'b000, code} + 8'd1;
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] inc5(input logic [IDX_W-1:0] x);
    return (x == IDX_W'(SIDE - 1)) ? '0 : x + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] dec5(input logic [IDX_W-1:0] x);
    return (x == '0) ? IDX_W'(SIDE - 1) : x - IDX_W'(1);
  endfunction

endpackage

// ===== design/pfc_lane.sv =====
// Lane: locates one letter in the key square and reports its row and column.
module pfc_lane (
  input  logic [pfc_pkg::CHAR_W-1:0] letter_i,
  input  pfc_pkg::key_sq_t           key_i,
  output pfc_pkg::pos_t              pos_o
);
  import pfc_pkg::*;

  logic [CODE_W-1:0] code;

  assign code = letter_code(letter_i);

  // Scan from the top so the lowest matching position wins; no match leaves 0.
  always_comb begin
    pos_o.ok  = is_letter(letter_i);
    pos_o.row = '0;
    pos_o.col = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (key_i[r][c] == code) begin
          pos_o.row = IDX_W'(r);
          pos_o.col = IDX_W'(c);
        end
      end
    end
  end

endmodule

// ===== design/pfc_merge.sv =====
// Merge stage: applies the row, column or rectangle rule and maps back to letters.
module pfc_merge (
  input  pfc_pkg::pos_t    a_i,
  input  pfc_pkg::pos_t    b_i,
  input  logic             decrypt_i,
  input  pfc_pkg::key_sq_t key_i,
  output pfc_pkg::res_t    res_o
);
  import pfc_pkg::*;

  logic [IDX_W-1:0] ar, ac, br, bc;

  function automatic logic [IDX_W-1:0] stepf(input logic [IDX_W-1:0] x, input logic dec);
    return dec ? dec5(x) : inc5(x);
  endfunction

  always_comb begin
    if (a_i.row == b_i.row) begin
      ar = a_i.row;
      br = b_i.row;
      ac = stepf(a_i.col, decrypt_i);
      bc = stepf(b_i.col, decrypt_i);
    end else if (a_i.col == b_i.col) begin
      ar = stepf(a_i.row, decrypt_i);
      br = stepf(b_i.row, decrypt_i);
      ac = a_i.col;
      bc = b_i.col;
    end else begin
      ar = a_i.row;
      br = b_i.row;
      ac = b_i.col;
      bc = a_i.col;
    end

    res_o.bad = !(a_i.ok && b_i.ok);
    if (res_o.bad) begin
      res_o.first  = '0;
      res_o.second = '0;
    end else begin
      res_o.first  = code_letter(key_i[ar][ac]);
      res_o.second = code_letter(key_i[br][bc]);
    end
  end

endmodule

// ===== design/playfair_digram_cipher_core.sv =====
// Top level of the Playfair digram cipher: config registers, two lanes and merge pipeline.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one digram word: two ASCII
//   letters. Output channel (out_valid_o / out_stall_i) carries the cipher word:
//   two letters plus bad_letter, which is set (letters zero) if either input
//   byte is outside A-Z. J is read as I.
//   Configuration goes through the APB-style port: 64-bit data, register i at
//   byte address 8*i (key rows 0-1, key rows 2-3, key row 4, direction).
//   Write registers only while no word is in flight.
// Timing:
//   An accepted word passes through two registers: one after the two letter
//   lanes, one after the merge stage, which drives the output. Throughput is
//   one digram per cycle while out_stall_i is low; each lane's 25-way compare
//   and the merge lookup each fit in a single stage.
// Reset:
//   rst_ni clears the config registers and the pipeline valid bits; payload
//   registers keep whatever they hold.
// Backpressure:
//   While out_stall_i holds, the result word stays put; the lane stage takes
//   one more word if it is empty, then in_stall_o rises until the output drains.
module playfair_digram_cipher_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [pfc_pkg::CHAR_W-1:0] first_letter_i,
  input  logic [pfc_pkg::CHAR_W-1:0] second_letter_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pfc_pkg::CHAR_W-1:0] out_first_o,
  output logic [pfc_pkg::CHAR_W-1:0] out_second_o,
  output logic                       bad_letter_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [4:0]                 paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import pfc_pkg::*;

  localparam int unsigned KEY2_W = 2 * SIDE * CODE_W;
  localparam int unsigned KEY1_W = SIDE * CODE_W;

  // Configuration registers
  logic [KEY2_W-1:0] key01_q, key23_q;
  logic [KEY1_W-1:0] key4_q;
  logic              dir_q;

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key01_q <= '0;
      key23_q <= '0;
      key4_q  <= '0;
      dir_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KEY01: key01_q <= pwdata[KEY2_W-1:0];
        REG_KEY23: key23_q <= pwdata[KEY2_W-1:0];
        REG_KEY4:  key4_q  <= pwdata[KEY1_W-1:0];
        REG_DIR:   dir_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_KEY01: prdata = {{(64-KEY2_W){1'b0}}, key01_q};
      REG_KEY23: prdata = {{(64-KEY2_W){1'b0}}, key23_q};
      REG_KEY4:  prdata = {{(64-KEY1_W){1'b0}}, key4_q};
      REG_DIR:   prdata = {63'd0, dir_q};
      default:   prdata = '0;
    endcase
  end

  // Unpack the square: rows 0-1, rows 2-3, row 4; code slot (row%2)*5+col, or col in row 4.
  key_sq_t key_sq;

  for (genvar r = 0; r < SIDE; r++) begin : g_row
    for (genvar c = 0; c < SIDE; c++) begin : g_col
      localparam int unsigned OFF = ((r % 2) * SIDE + c) * CODE_W;
      if (r < 2) begin : g_a
        assign key_sq[r][c] = key01_q[OFF +: CODE_W];
      end else if (r < 4) begin : g_b
        assign key_sq[r][c] = key23_q[OFF +: CODE_W];
      end else begin : g_c
        assign key_sq[r][c] = key4_q[c*CODE_W +: CODE_W];
      end
    end
  end

  // Stage 1: one lane per letter
  pos_t lane_a, lane_b;
  pos_t pa_q, pb_q;
  logic s1_valid_q;

  pfc_lane u_lane_a (.letter_i(first_letter_i),  .key_i(key_sq), .pos_o(lane_a));
  pfc_lane u_lane_b (.letter_i(second_letter_i), .key_i(key_sq), .pos_o(lane_b));

  // Stage 2: merge into the output register
  res_t merged, res_q;

  pfc_merge u_merge (
    .a_i      (pa_q),
    .b_i      (pb_q),
    .decrypt_i(dir_q),
    .key_i    (key_sq),
    .res_o    (merged)
  );

  logic s2_load, s1_load;

  // Output register frees when empty or taken; stage 1 loads when empty or when stage 2 can load.
  assign s2_load    = !out_valid_o || !out_stall_i;
  assign s1_load    = !s1_valid_q || s2_load;
  assign in_stall_o = !s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_load) begin
        out_valid_o <= s1_valid_q;
      end
    end
  end

  // Payload: no reset, advance with the valid bits
  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      pa_q <= lane_a;
      pb_q <= lane_b;
    end
    if (s2_load && s1_valid_q) begin
      res_q <= merged;
    end
  end

  assign out_first_o  = res_q.first;
  assign out_second_o = res_q.second;
  assign bad_letter_o = res_q.bad;

endmodule

// ===== design/pfc_checker.sv =====
// Port-level checker for the Playfair digram cipher, bound to the top level.
module pfc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [pfc_pkg::CHAR_W-1:0] out_first_o,
  input logic [pfc_pkg::CHAR_W-1:0] out_second_o,
  input logic                       bad_letter_o
);
  import pfc_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_first_o)
      && $stable(out_second_o) && $stable(bad_letter_o))
    else $error("stalled result word changed");

  // A flagged word carries zero letters
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_letter_o |-> out_first_o == '0 && out_second_o == '0)
    else $error("bad word carries letters");

  // A good word carries uppercase letters other than J
  a_good_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_letter_o |-> out_first_o >= CHAR_A && out_first_o <= CHAR_Z
      && out_second_o >= CHAR_A && out_second_o <= CHAR_Z
      && out_first_o != 8'h4A && out_second_o != 8'h4A)
    else $error("result letter out of range");

  // An accepted word reaches the output without backpressure
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted word did not reach output");

endmodule

bind playfair_digram_cipher_core pfc_checker u_pfc_checker (.*);
